FILE: rtl/sus_pkg.sv
// Package for the sorted unique key set: request and status codes,
// sequencer states and the packed request and result transfer types.
// No dependencies; every file of the block imports it.
package sus_pkg;

  localparam int WordW  = 64;
  localparam int KeyW   = 4 * WordW;
  localparam int IdxW   = 6;
  localparam int FieldW = 7;

  // Request kinds carried in req_type.
  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_PRE,
    ST_SHIFT,
    ST_INSERT,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [WordW-1:0] key_word3;
    logic [WordW-1:0] key_word2;
    logic [WordW-1:0] key_word1;
    logic [WordW-1:0] key_word0;
    logic [IdxW-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FieldW-1:0] position;
    logic [FieldW-1:0] entry_total;
    logic [WordW-1:0]  out_word3;
    logic [WordW-1:0]  out_word2;
    logic [WordW-1:0]  out_word1;
    logic [WordW-1:0]  out_word0;
  } rsp_t;

endpackage

FILE: rtl/sorted_unique_key_set.sv
// Sorted set of unique 256-bit keys with a single-port-pair key memory.
// Depends on sus_pkg for the transfer types, codes and sequencer states.
//
// Usage:
//   One request channel (in_valid_i, in_stall_o, in_data_i) and one result
//   channel (out_valid_o, out_stall_i, out_data_o). A transfer happens on a
//   rising edge with valid high and stall low. Every request gives exactly
//   one result, in request order.
//   Add: the key memory is scanned from index 0, one stored key compared
//   per cycle, until the key is found (duplicate), a larger key is met or
//   all keys are passed. Later entries then move up one place per cycle
//   and the key is written. The single memory read port and the one
//   256-bit comparator let an add work on one entry at a time. A read
//   does a memory read, then captures the result. Clear, unused request
//   kinds, a full set and an index out of range go straight to the result.
//   Only one request is worked on at a time: in_stall_o is high from the
//   transfer until the result has moved into the output register, so
//   in_stall_o falls in the same cycle as out_valid_o rises.
//   The output register holds its result while out_stall_i is high, and the
//   next request may already be taken in meanwhile.
//   Reset empties the set (entry count zero); the key memory is not cleared
//   because entries at or above the count are never read.
module sorted_unique_key_set
  import sus_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = (CW > IdxW) ? CW : IdxW;

  state_e state_q, state_d;

  logic [KeyW-1:0] key_q, key_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  rsp_t            res_q, res_d;
  rsp_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // Key memory with registered read data.
  logic [KeyW-1:0] mem [MAX_ENTRIES];
  logic [KeyW-1:0] rdata_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [KeyW-1:0] wr_data;

  // Shared comparator and derived conditions.
  logic            key_lt, key_eq;
  logic            in_xfer, out_free, is_full, idx_in_range;
  logic            scan_last, shift_last;
  logic [CW-1:0]   idx_inc, idx_dec;
  logic [KeyW-1:0] in_key;

  assign key_lt = key_q < rdata_q;
  assign key_eq = key_q == rdata_q;

  assign in_stall_o   = state_q != ST_IDLE;
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign is_full      = count_q >= CW'(MAX_ENTRIES);
  assign idx_in_range = XW'(in_data_i.read_index) < XW'(count_q);
  assign idx_inc      = idx_q + CW'(1);
  assign idx_dec      = idx_q - CW'(1);
  assign scan_last    = idx_inc == count_q;
  assign shift_last   = idx_dec == pos_q;
  assign in_key       = {in_data_i.key_word3, in_data_i.key_word2,
                         in_data_i.key_word1, in_data_i.key_word0};

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_data_i.req_type)
            REQ_ADD: begin
              if (is_full) begin
                state_d = ST_RESP;
              end else if (count_q == '0) begin
                state_d = ST_INSERT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            REQ_READ: state_d = idx_in_range ? ST_READ : ST_RESP;
            REQ_CLEAR: state_d = ST_RESP;
            REQ_NOP: state_d = ST_RESP;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        priority if (key_eq) begin
          state_d = ST_RESP;
        end else if (key_lt) begin
          state_d = ST_SHIFT_PRE;
        end else if (scan_last) begin
          state_d = ST_INSERT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SHIFT_PRE: state_d = ST_SHIFT;
      ST_SHIFT: begin
        if (shift_last) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: state_d = ST_RESP;
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates of the sequencer.
  always_comb begin
    key_d       = key_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rdata_q;

    // The output register empties once its transfer completes.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          key_d             = in_key;
          res_d             = '0;
          res_d.status      = STAT_OK;
          res_d.entry_total = FieldW'(count_q);
          unique case (in_data_i.req_type)
            REQ_ADD: begin
              idx_d = '0;
              pos_d = '0;
              if (is_full) begin
                res_d.status = STAT_FULL;
              end else if (count_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
              end
            end
            REQ_CLEAR: begin
              count_d           = '0;
              res_d.entry_total = '0;
            end
            REQ_READ: begin
              if (idx_in_range) begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_data_i.read_index);
                pos_d   = CW'(in_data_i.read_index);
              end else begin
                res_d.status = STAT_RANGE;
              end
            end
            REQ_NOP: ;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        priority if (key_eq) begin
          res_d.status = STAT_DUP;
        end else if (key_lt) begin
          pos_d = idx_q;
        end else if (scan_last) begin
          pos_d = count_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_inc);
          idx_d   = idx_inc;
        end
      end
      ST_SHIFT_PRE: begin
        // Fetch the last entry; it moves up first.
        rd_en   = 1'b1;
        rd_addr = AW'(count_q - CW'(1));
        idx_d   = count_q;
      end
      ST_SHIFT: begin
        // rdata_q holds entry idx-1, which moves up to idx.
        wr_en   = 1'b1;
        wr_addr = AW'(idx_q);
        wr_data = rdata_q;
        if (!shift_last) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q - CW'(2));
          idx_d   = idx_dec;
        end
      end
      ST_INSERT: begin
        wr_en             = 1'b1;
        wr_addr           = AW'(pos_q);
        wr_data           = key_q;
        count_d           = count_q + CW'(1);
        res_d.status      = STAT_OK;
        res_d.position    = FieldW'(pos_q);
        res_d.entry_total = FieldW'(count_q + CW'(1));
      end
      ST_READ: begin
        res_d.position  = FieldW'(pos_q);
        res_d.out_word3 = rdata_q[4*WordW-1:3*WordW];
        res_d.out_word2 = rdata_q[3*WordW-1:2*WordW];
        res_d.out_word1 = rdata_q[2*WordW-1:WordW];
        res_d.out_word0 = rdata_q[WordW-1:0];
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // Key memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  // A scan only visits held entries.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q < count_q))
    else $error("scan index beyond entry count");

  // Entries only move into places above the insert position.
  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (idx_q > pos_q && idx_q <= count_q))
    else $error("shift index outside the moved range");

  // An insert grows the set by exactly one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count by one");

  // The memory is written only while moving entries or inserting.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_SHIFT || state_q == ST_INSERT))
    else $error("memory write outside shift or insert");

endmodule
